>>> rtl/core/rv32alu_pkg.sv
// Shared types, operation codes and the divider step for the rv32_alu pipeline.
package rv32alu_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned OPW  = 4;

    typedef enum logic [OPW-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_PASA = 4'd2,
        OP_PASB = 4'd3,
        OP_MUL  = 4'd4,
        OP_DIVU = 4'd5,
        OP_REMU = 4'd6,
        OP_SLL  = 4'd7,
        OP_SLT  = 4'd8,
        OP_SLTU = 4'd9,
        OP_XOR  = 4'd10,
        OP_SRL  = 4'd11,
        OP_SRA  = 4'd12,
        OP_OR   = 4'd13,
        OP_AND  = 4'd14
    } t_alu_op;

    typedef struct packed {
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
    } t_div_st;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic t_div_st div_step(t_div_st s, logic [XLEN-1:0] den);
        logic [XLEN:0] sh;
        logic [XLEN:0] diff;
        t_div_st       o;
        sh   = {s.rem, s.quo[XLEN-1]};
        diff = sh - {1'b0, den};
        if (!diff[XLEN]) begin
            o.rem = diff[XLEN-1:0];
            o.quo = {s.quo[XLEN-2:0], 1'b1};
        end else begin
            o.rem = sh[XLEN-1:0];
            o.quo = {s.quo[XLEN-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> rtl/core/rv32alu_div.sv
// Fully pipelined unsigned divider, one quotient bit per stage.
module rv32alu_div
    import rv32alu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [XLEN-1:0] i_dividend,
    input  logic [XLEN-1:0] i_divisor,
    output logic [XLEN-1:0] o_quotient,
    output logic [XLEN-1:0] o_remainder
);

    t_div_st         r_st  [0:XLEN-1];
    logic [XLEN-1:0] r_den [0:XLEN-2];
    t_div_st         n_st  [0:XLEN-1];

    always_comb begin
        n_st[0] = div_step(t_div_st'{rem: '0, quo: i_dividend}, i_divisor);
        for (int k = 1; k < XLEN; k++) begin
            n_st[k] = div_step(r_st[k-1], r_den[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]  <= n_st[0];
            r_den[0] <= i_divisor;
            for (int k = 1; k < XLEN; k++) begin
                r_st[k] <= n_st[k];
            end
            for (int k = 1; k < XLEN - 1; k++) begin
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quotient  = r_st[XLEN-1].quo;
    assign o_remainder = r_st[XLEN-1].rem;

endmodule

>>> rtl/core/rv32_alu.sv
// Top level of the rv32_alu pipeline: fast ops, split multiplier, divider.
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+--------------------------------------------
//  input    | i_valid | o_ready | i_operation, i_operand_a, i_operand_b
//  output   | o_valid | i_ready | o_result
//
// One beat enters per cycle while the output is not stalled; the 32-stage
// divider lies between the input register and the output register.
// All ops travel the same depth, so results leave in order.
// A stalled output beat holds the whole pipeline; bubbles inside it are not filled.
// Reset clears all valid bits; payload registers are not reset.
module rv32_alu
    import rv32alu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [OPW-1:0]  i_operation,
    input  logic [XLEN-1:0] i_operand_a,
    input  logic [XLEN-1:0] i_operand_b,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [XLEN-1:0] o_result
);

    localparam int unsigned NST = XLEN + 1;

    logic                r_vld [0:NST-1];
    logic [OPW-1:0]      r_op  [0:NST-1];
    logic [XLEN-1:0]     r_res [1:NST-1];
    logic [XLEN-1:0]     r_a;
    logic [XLEN-1:0]     r_b;
    logic [XLEN-1:0]     r_ll;
    logic [XLEN/2-1:0]   r_mid;
    logic                r_ovld;
    logic [XLEN-1:0]     r_out;

    logic                ce;
    logic [XLEN-1:0]     n_fast;
    logic [XLEN-1:0]     n_ll;
    logic [XLEN-1:0]     n_mid;
    logic [XLEN-1:0]     n_mul;
    logic [XLEN-1:0]     n_out;
    logic [XLEN-1:0]     div_q;
    logic [XLEN-1:0]     div_r;
    logic [4:0]          shamt;

    assign ce      = !r_ovld || i_ready;
    assign o_ready = ce;
    assign o_valid = r_ovld;
    assign o_result = r_out;
    assign shamt   = r_b[4:0];

    always_comb begin
        case (t_alu_op'(r_op[0]))
            OP_ADD:  n_fast = r_a + r_b;
            OP_SUB:  n_fast = r_a - r_b;
            OP_PASA: n_fast = r_a;
            OP_PASB: n_fast = r_b;
            OP_SLL:  n_fast = r_a << shamt;
            OP_SLT:  n_fast = {{(XLEN-1){1'b0}}, $signed(r_a) < $signed(r_b)};
            OP_SLTU: n_fast = {{(XLEN-1){1'b0}}, r_a < r_b};
            OP_XOR:  n_fast = r_a ^ r_b;
            OP_SRL:  n_fast = r_a >> shamt;
            OP_SRA:  n_fast = XLEN'($signed(r_a) >>> shamt);
            OP_OR:   n_fast = r_a | r_b;
            OP_AND:  n_fast = r_a & r_b;
            default: n_fast = '0;
        endcase
    end

    // Low word of the product from three 16x16 partial products.
    assign n_ll  = {16'd0, r_a[15:0]} * {16'd0, r_b[15:0]};
    assign n_mid = {16'd0, r_a[31:16]} * {16'd0, r_b[15:0]}
                 + {16'd0, r_a[15:0]} * {16'd0, r_b[31:16]};
    assign n_mul = r_ll + {r_mid, 16'd0};

    always_comb begin
        case (t_alu_op'(r_op[NST-1]))
            OP_DIVU: n_out = div_q;
            OP_REMU: n_out = div_r;
            default: n_out = r_res[NST-1];
        endcase
    end

    rv32alu_div u_div (
        .i_clk       (i_clk),
        .i_en        (ce),
        .i_dividend  (r_a),
        .i_divisor   (r_b),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (ce) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ovld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_op[0] <= i_operation;
            r_a     <= i_operand_a;
            r_b     <= i_operand_b;
            for (int k = 1; k < NST; k++) begin
                r_op[k] <= r_op[k-1];
            end
            r_res[1] <= n_fast;
            r_ll     <= n_ll;
            r_mid    <= n_mid[XLEN/2-1:0];
            r_res[2] <= (t_alu_op'(r_op[1]) == OP_MUL) ? n_mul : r_res[1];
            for (int k = 3; k < NST; k++) begin
                r_res[k] <= r_res[k-1];
            end
            r_out <= n_out;
        end
    end

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_vld[0] && !r_vld[NST-1])
        else $error("valid bits not cleared by reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ce |=> $stable(r_vld[NST-1]) && $stable(r_op[NST-1]) && $stable(r_res[NST-1]))
        else $error("pipeline moved during stall");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!r_ovld || i_ready))
        else $error("input ready out of step with output stall");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ce && r_vld[NST-1] |=> o_valid)
        else $error("finished beat dropped before output");

endmodule

>>> sim/rv32_alu_tb.sv
// Self-checking testbench for the rv32_alu pipeline: random ops, stalls and result checks.
`timescale 1ns / 1ps

module rv32_alu_tb;
    import rv32alu_pkg::*;

    localparam int unsigned LATENCY     = 34;
    localparam int unsigned N_RANDOM    = 1950;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [OPW-1:0] OP_UNUSED = 4'd15;

    typedef struct {
        logic [OPW-1:0]  op;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
    } t_alu_req;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    logic [OPW-1:0]  i_operation;
    logic [XLEN-1:0] i_operand_a;
    logic [XLEN-1:0] i_operand_b;
    logic            o_valid;
    logic            i_ready;
    logic [XLEN-1:0] o_result;

    rv32_alu dut (.*);

    t_alu_req        req_q[$];
    logic [XLEN-1:0] result_q[$];
    int unsigned     n_err;
    int unsigned     n_sent;
    int unsigned     n_checked;
    int unsigned     cycle;
    int unsigned     send_idle;
    int unsigned     recv_idle;
    int unsigned     hold_cnt;
    bit              hold_done;
    bit              quiet;
    bit              stim_done;

    // Compute what the ALU should return for one operation.
    function automatic logic [XLEN-1:0] alu_result(logic [OPW-1:0] op,
                                                   logic [XLEN-1:0] a,
                                                   logic [XLEN-1:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (op)
            OP_ADD:  return a + b;
            OP_SUB:  return a - b;
            OP_PASA: return a;
            OP_PASB: return b;
            OP_MUL:  return a * b;
            OP_DIVU: return (b == 0) ? '1 : a / b;
            OP_REMU: return (b == 0) ? a : a % b;
            OP_SLL:  return a << sh;
            OP_SLT:  return ($signed(a) < $signed(b)) ? 1 : 0;
            OP_SLTU: return (a < b) ? 1 : 0;
            OP_XOR:  return a ^ b;
            OP_SRL:  return a >> sh;
            OP_SRA:  return $unsigned($signed(a) >>> sh);
            OP_OR:   return a | b;
            OP_AND:  return a & b;
            default: return '0;
        endcase
    endfunction

    function automatic logic [XLEN-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_req(logic [OPW-1:0] op, logic [XLEN-1:0] a, logic [XLEN-1:0] b);
        t_alu_req r;
        r.op = op;
        r.a  = a;
        r.b  = b;
        req_q.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        t_alu_op op;
        i_rst_n = 1'b0;
        // Directed: every op on extreme operands, plus division, shift, SLT and unused op code corner cases.
        op = op.first();
        do begin
            push_req(op, 32'hffff_ffff, 32'h8000_0000);
            op = op.next();
        end while (op != op.first());
        push_req(OP_DIVU, 32'h1234_5678, 32'h0);
        push_req(OP_REMU, 32'h1234_5678, 32'h0);
        push_req(OP_SLL,  32'h0000_0001, 32'hffff_ffe3);
        push_req(OP_SRA,  32'h8000_0000, 32'h0000_003f);
        push_req(OP_SRL,  32'h8000_0000, 32'h0000_0020);
        push_req(OP_SLT,  32'h7fff_ffff, 32'h8000_0000);
        push_req(OP_ADD,  32'h0, 32'h0);
        push_req(OP_UNUSED, 32'hdead_beef, 32'h1);
        push_req(OP_DIVU, 32'h8000_0000, 32'hffff_ffff);
        for (int i = 0; i < N_RANDOM; i++)
            push_req(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: one beat from the queue, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_operation <= '0;
            i_operand_a <= '0;
            i_operand_b <= '0;
            send_idle   <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                result_q.push_back(alu_result(i_operation, i_operand_a, i_operand_b));
                n_sent <= n_sent + 1;
            end
            if (send_idle != 0) begin
                send_idle <= send_idle - 1;
                i_valid   <= 1'b0;
            end else if (req_q.size() != 0) begin
                t_alu_req r;
                r = req_q.pop_front();
                i_valid     <= 1'b1;
                i_operation <= r.op;
                i_operand_a <= r.a;
                i_operand_b <= r.b;
                if (!quiet && $urandom_range(0, 9) == 0)
                    send_idle <= $urandom_range(1, 10);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure: one long hold-off, then random bursts, none at the end.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            recv_idle <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_sent >= 100) begin
            i_ready  <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == 3 * LATENCY)
                hold_done <= 1'b1;
        end else if (recv_idle != 0) begin
            recv_idle <= recv_idle - 1;
            i_ready   <= (recv_idle == 1);
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_idle <= $urandom_range(1, 10);
            i_ready   <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                n_err <= n_err + 1;
                if (n_err < 10)
                    $display("unexpected result beat %h", o_result);
            end else begin
                logic [XLEN-1:0] want;
                want = result_q.pop_front();
                n_checked <= n_checked + 1;
                if (o_result !== want) begin
                    n_err <= n_err + 1;
                    if (n_err < 10)
                        $display("mismatch #%0d: expected %h got %h", n_checked, want, o_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        quiet <= (req_q.size() < 200);
        if (cycle >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        n_err = 0;
        n_sent = 0;
        n_checked = 0;
        cycle = 0;
        quiet = 1'b0;
        stim_done = 1'b0;
        wait (i_rst_n === 1'b1);
        wait (req_q.size() == 0 && !i_valid);
        wait (result_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("checked %0d results over all 16 op codes, with operand extremes,", n_checked);
        $display("zero divisors, oversized shifts, idle bursts and a long output stall");
        if (n_err == 0 && result_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rv32alu_pkg.sv
rtl/core/rv32alu_div.sv
rtl/core/rv32_alu.sv
sim/rv32_alu_tb.sv
